// ===== hw/rtl/cnms_pkg.sv =====
package cnms_pkg;

  localparam int THR_W      = 38;
  localparam int CFG_W      = 38;
  localparam int IW_W       = 12;
  localparam int COL_W      = 11;
  localparam int TAN_W      = 14;
  localparam int TAN22_Q15  = 13573;
  localparam int TAN_SHIFT  = 15;
  localparam int DIAG_SHIFT = 16;

  localparam logic [IW_W-1:0] WIDTH_RESET = 12'd640;

  typedef enum logic [1:0] {
    REG_LOW_THR  = 2'd0,
    REG_HIGH_THR = 2'd1,
    REG_L2       = 2'd2,
    REG_WIDTH    = 2'd3
  } reg_index_t;

  typedef enum logic [1:0] {
    CLASS_WEAK   = 2'd0,
    CLASS_NONE   = 2'd1,
    CLASS_STRONG = 2'd2
  } edge_class_t;

  typedef enum logic [1:0] {
    DIR_HORZ = 2'd0,
    DIR_VERT = 2'd1,
    DIR_DIAG = 2'd2
  } dir_t;

  typedef struct packed {
    logic valid;
    logic first;
    logic last;
    logic emit_prev;
    logic emit_last;
    logic eof;
  } op_ctrl_t;

  typedef struct packed {
    edge_class_t      cls;
    logic [COL_W-1:0] col;
    logic             eor;
    logic             eof;
  } result_t;

endpackage

// ===== hw/rtl/canny_nonmax_suppression_core.sv =====
// order: a pixel's class enters the result queue after the pixel one column to its right
//   (one row below) passes the pipeline registers; the last column comes out with it
// throughput: one pixel per cycle through the line-store pipeline, up to two words per
//   pixel at row ends into a QUEUE_DEPTH-word queue; full bars pushes when it runs short
// reset: synchronous, clears counters, pipeline valids, queue and config to defaults;
//   line stores are not cleared, the rows above a frame's first row read as zero
module canny_nonmax_suppression_core #(
  parameter int MAX_WIDTH   = 2048,
  parameter int GRAD_BITS   = 19,
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        write_enable,
  input  logic [1:0]                  reg_index,
  input  logic [cnms_pkg::CFG_W-1:0]  write_data,
  input  logic                        push,
  output logic                        full,
  input  logic signed [GRAD_BITS-1:0] grad_x,
  input  logic signed [GRAD_BITS-1:0] grad_y,
  input  logic                        padding_row,
  output logic                        empty,
  input  logic                        pop,
  output logic [1:0]                  edge_class,
  output logic [cnms_pkg::COL_W-1:0]  pixel_column,
  output logic                        end_of_row,
  output logic                        end_of_frame
);

  localparam int CW = $clog2(MAX_WIDTH);

  logic [cnms_pkg::THR_W-1:0] low_threshold;
  logic [cnms_pkg::THR_W-1:0] high_threshold;
  logic                       l2_magnitude;
  logic [cnms_pkg::IW_W-1:0]  image_width;

  cnms_pkg::op_ctrl_t op;
  logic [CW-1:0]      column;
  logic               word_taken;
  logic               push0;
  logic               push1;
  cnms_pkg::result_t  word0;
  cnms_pkg::result_t  word1;
  cnms_pkg::result_t  head;

  always_ff @(posedge clk) begin
    if (rst) begin
      low_threshold  <= '0;
      high_threshold <= '0;
      l2_magnitude   <= 1'b0;
      image_width    <= cnms_pkg::WIDTH_RESET;
    end else if (write_enable) begin
      unique case (cnms_pkg::reg_index_t'(reg_index))
        cnms_pkg::REG_LOW_THR:  low_threshold  <= write_data[cnms_pkg::THR_W-1:0];
        cnms_pkg::REG_HIGH_THR: high_threshold <= write_data[cnms_pkg::THR_W-1:0];
        cnms_pkg::REG_L2:       l2_magnitude   <= write_data[0];
        cnms_pkg::REG_WIDTH:    image_width    <= write_data[cnms_pkg::IW_W-1:0];
        default:                l2_magnitude   <= l2_magnitude;
      endcase
    end
  end

  cnms_front #(.MAX_WIDTH(MAX_WIDTH), .QUEUE_DEPTH(QUEUE_DEPTH)) u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .padding_row (padding_row),
    .image_width (image_width),
    .word_taken  (word_taken),
    .full        (full),
    .op          (op),
    .column      (column)
  );

  cnms_datapath #(.MAX_WIDTH(MAX_WIDTH), .GRAD_BITS(GRAD_BITS)) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .op       (op),
    .column   (column),
    .grad_x   (grad_x),
    .grad_y   (grad_y),
    .low_thr  (low_threshold),
    .high_thr (high_threshold),
    .l2_mode  (l2_magnitude),
    .push0    (push0),
    .push1    (push1),
    .word0    (word0),
    .word1    (word1)
  );

  cnms_outq #(.DEPTH(QUEUE_DEPTH)) u_outq (
    .clk        (clk),
    .rst        (rst),
    .push0      (push0),
    .push1      (push1),
    .word0      (word0),
    .word1      (word1),
    .pop        (pop),
    .empty      (empty),
    .word_taken (word_taken),
    .head       (head)
  );

  assign edge_class   = head.cls;
  assign pixel_column = head.col;
  assign end_of_row   = head.eor;
  assign end_of_frame = head.eof;

endmodule

// ===== hw/rtl/cnms_ram.sv =====
module cnms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/cnms_classify.sv =====
module cnms_classify #(
  parameter int MAG_W = 38
) (
  input  logic [cnms_pkg::THR_W-1:0] low_thr,
  input  logic [cnms_pkg::THR_W-1:0] high_thr,
  input  cnms_pkg::dir_t             dir,
  input  logic                       neg,
  input  logic [MAG_W-1:0]           m,
  input  logic [MAG_W-1:0]           left,
  input  logic [MAG_W-1:0]           right,
  input  logic [MAG_W-1:0]           up_l,
  input  logic [MAG_W-1:0]           up_c,
  input  logic [MAG_W-1:0]           up_r,
  input  logic [MAG_W-1:0]           dn_l,
  input  logic [MAG_W-1:0]           dn_c,
  input  logic [MAG_W-1:0]           dn_r,
  output cnms_pkg::edge_class_t      cls
);

  localparam int KW = (MAG_W > cnms_pkg::THR_W) ? MAG_W : cnms_pkg::THR_W;

  logic [KW-1:0]    mk;
  logic [KW-1:0]    lowk;
  logic [KW-1:0]    highk;
  logic [MAG_W-1:0] n_a;
  logic [MAG_W-1:0] n_b;
  logic             strict_b;
  logic             keep;

  always_comb begin
    mk       = KW'(m);
    lowk     = KW'(low_thr);
    highk    = KW'(high_thr);
    n_a      = left;
    n_b      = right;
    strict_b = 1'b0;
    unique case (dir)
      cnms_pkg::DIR_HORZ: begin
        n_a = left;
        n_b = right;
      end
      cnms_pkg::DIR_VERT: begin
        n_a = up_c;
        n_b = dn_c;
      end
      cnms_pkg::DIR_DIAG: begin
        strict_b = 1'b1;
        n_a      = neg ? up_r : up_l;
        n_b      = neg ? dn_l : dn_r;
      end
      default: begin
        n_a = left;
        n_b = right;
      end
    endcase
    keep = (m > n_a) && (strict_b ? (m > n_b) : (m >= n_b));
    if (mk <= lowk || !keep) begin
      cls = cnms_pkg::CLASS_NONE;
    end else if (mk > highk) begin
      cls = cnms_pkg::CLASS_STRONG;
    end else begin
      cls = cnms_pkg::CLASS_WEAK;
    end
  end

endmodule

// ===== hw/rtl/cnms_front.sv =====
module cnms_front #(
  parameter int MAX_WIDTH   = 2048,
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  input  logic                            padding_row,
  input  logic [cnms_pkg::IW_W-1:0]       image_width,
  input  logic                            word_taken,
  output logic                            full,
  output cnms_pkg::op_ctrl_t              op,
  output logic [$clog2(MAX_WIDTH)-1:0]    column
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(QUEUE_DEPTH) + 1;

  logic [CW-1:0] column_count;
  logic [CW-1:0] column_count_next;
  logic          first_row;
  logic          first_row_next;
  logic [RW-1:0] reserved;
  logic [RW-1:0] reserved_next;
  logic [31:0]   width_eff;
  logic [CW-1:0] last_col;
  logic [CW-1:0] col;
  logic          accept;
  logic [1:0]    n_words;

  always_comb begin
    width_eff = 32'(image_width);
    if (width_eff < 32'd3) begin
      width_eff = 32'd3;
    end
    if (width_eff > 32'(MAX_WIDTH)) begin
      width_eff = 32'(MAX_WIDTH);
    end
    last_col = CW'(width_eff - 32'd1);
  end

  assign full   = reserved > RW'(QUEUE_DEPTH - 2);
  assign accept = push && !full;
  assign col    = (column_count > last_col) ? last_col : column_count;
  assign column = col;

  always_comb begin
    op.valid     = accept && !(padding_row && first_row);
    op.first     = first_row;
    op.last      = col == last_col;
    op.emit_prev = !first_row && (col != '0);
    op.emit_last = !first_row && (col == last_col);
    op.eof       = padding_row;
    n_words      = op.valid ? ({1'b0, op.emit_prev} + {1'b0, op.emit_last}) : 2'd0;

    column_count_next = column_count;
    first_row_next    = first_row;
    if (op.valid) begin
      if (op.last) begin
        column_count_next = '0;
        if (first_row) begin
          first_row_next = 1'b0;
        end else if (padding_row) begin
          first_row_next = 1'b1;
        end
      end else begin
        column_count_next = col + 1'b1;
      end
    end
    reserved_next = reserved + RW'(n_words) - RW'(word_taken);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      first_row    <= 1'b1;
      reserved     <= '0;
    end else begin
      column_count <= column_count_next;
      first_row    <= first_row_next;
      reserved     <= reserved_next;
    end
  end

endmodule

// ===== hw/rtl/cnms_datapath.sv =====
module cnms_datapath #(
  parameter int MAX_WIDTH = 2048,
  parameter int GRAD_BITS = 19
) (
  input  logic                            clk,
  input  logic                            rst,
  input  cnms_pkg::op_ctrl_t              op,
  input  logic [$clog2(MAX_WIDTH)-1:0]    column,
  input  logic signed [GRAD_BITS-1:0]     grad_x,
  input  logic signed [GRAD_BITS-1:0]     grad_y,
  input  logic [cnms_pkg::THR_W-1:0]      low_thr,
  input  logic [cnms_pkg::THR_W-1:0]      high_thr,
  input  logic                            l2_mode,
  output logic                            push0,
  output logic                            push1,
  output cnms_pkg::result_t               word0,
  output cnms_pkg::result_t               word1
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int GB    = GRAD_BITS;
  localparam int MW    = 2 * GRAD_BITS;
  localparam int TW    = GRAD_BITS + cnms_pkg::TAN_W;
  localparam int SW    = GRAD_BITS + 17;
  localparam int COL_W = cnms_pkg::COL_W;

  localparam logic [cnms_pkg::TAN_W-1:0] TAN22 = cnms_pkg::TAN_W'(cnms_pkg::TAN22_Q15);

  // accept stage
  logic signed [GB-1:0] dx_in;
  logic signed [GB-1:0] dy_in;
  logic [2*GB-1:0]      g_old;
  logic [MW-1:0]        up1_raw;
  logic [MW-1:0]        up2_raw;

  // stage 1
  cnms_pkg::op_ctrl_t   ctrl1;
  logic [CW-1:0]        c1;
  logic signed [GB-1:0] dx1;
  logic signed [GB-1:0] dy1;
  logic [GB-1:0]        ax1;
  logic [GB-1:0]        ay1;
  logic [GB-1:0]        gx1;
  logic [GB-1:0]        gy1;
  logic [GB-1:0]        gxa1;
  logic [GB-1:0]        gya1;
  logic [MW-1:0]        sqx1;
  logic [MW-1:0]        sqy1;
  logic [TW-1:0]        tg1;
  logic [MW-1:0]        up1_m;

  // stage 2
  cnms_pkg::op_ctrl_t   ctrl2;
  logic [CW-1:0]        c2;
  logic [MW-1:0]        sqx2;
  logic [MW-1:0]        sqy2;
  logic [GB-1:0]        ax2;
  logic [GB-1:0]        ay2;
  logic [GB-1:0]        gxa2;
  logic [GB-1:0]        gya2;
  logic [TW-1:0]        tg2;
  logic                 neg2;
  logic [MW-1:0]        up1_2;
  logic [MW-1:0]        up2_2;
  logic [MW-1:0]        mag2;
  logic [SW-1:0]        y2;
  logic [SW-1:0]        t2;
  logic [SW-1:0]        bound2;
  cnms_pkg::dir_t       dir2;

  // stage 3
  cnms_pkg::op_ctrl_t   ctrl3;
  logic [CW-1:0]        c3;
  logic [MW-1:0]        mag3;
  logic [MW-1:0]        up1_3;
  logic [MW-1:0]        up2_3;
  cnms_pkg::dir_t       dir3;
  logic                 neg3;

  // 3-column windows, index 2 is the newest column
  logic [MW-1:0]        cur_w  [3];
  logic [MW-1:0]        row1_w [3];
  logic [MW-1:0]        row2_w [3];
  cnms_pkg::dir_t       dir_w  [2];
  logic                 neg_w  [2];
  cnms_pkg::op_ctrl_t   ctrl4;
  logic [CW-1:0]        c4;

  cnms_pkg::edge_class_t cls_prev;
  cnms_pkg::edge_class_t cls_last;
  cnms_pkg::result_t     prev_word;
  cnms_pkg::result_t     last_word;

  assign dx_in = op.eof ? '0 : grad_x;
  assign dy_in = op.eof ? '0 : grad_y;

  cnms_ram #(.WIDTH(2 * GB), .DEPTH(MAX_WIDTH)) u_grad_ram (
    .clk   (clk),
    .we    (op.valid),
    .waddr (column),
    .wdata ({dy_in, dx_in}),
    .raddr (column),
    .rdata (g_old)
  );

  cnms_ram #(.WIDTH(MW), .DEPTH(MAX_WIDTH)) u_row1_ram (
    .clk   (clk),
    .we    (ctrl2.valid),
    .waddr (c2),
    .wdata (mag2),
    .raddr (column),
    .rdata (up1_raw)
  );

  cnms_ram #(.WIDTH(MW), .DEPTH(MAX_WIDTH)) u_row2_ram (
    .clk   (clk),
    .we    (ctrl2.valid),
    .waddr (c2),
    .wdata (up1_2),
    .raddr (column),
    .rdata (up2_raw)
  );

  always_comb begin
    ax1   = dx1[GB-1] ? (~dx1 + 1'b1) : dx1;
    ay1   = dy1[GB-1] ? (~dy1 + 1'b1) : dy1;
    gx1   = g_old[GB-1:0];
    gy1   = g_old[2*GB-1:GB];
    gxa1  = gx1[GB-1] ? (~gx1 + 1'b1) : gx1;
    gya1  = gy1[GB-1] ? (~gy1 + 1'b1) : gy1;
    sqx1  = MW'(ax1) * MW'(ax1);
    sqy1  = MW'(ay1) * MW'(ay1);
    tg1   = TW'(gxa1) * TW'(TAN22);
    up1_m = ctrl1.first ? '0 : up1_raw;
  end

  always_comb begin
    mag2   = l2_mode ? (sqx2 + sqy2) : (MW'(ax2) + MW'(ay2));
    y2     = SW'(gya2) << cnms_pkg::TAN_SHIFT;
    t2     = SW'(tg2);
    bound2 = t2 + (SW'(gxa2) << cnms_pkg::DIAG_SHIFT);
    if (y2 < t2) begin
      dir2 = cnms_pkg::DIR_HORZ;
    end else if (y2 > bound2) begin
      dir2 = cnms_pkg::DIR_VERT;
    end else begin
      dir2 = cnms_pkg::DIR_DIAG;
    end
  end

  always_ff @(posedge clk) begin
    ctrl1 <= op;
    c1    <= column;
    dx1   <= dx_in;
    dy1   <= dy_in;

    ctrl2 <= ctrl1;
    c2    <= c1;
    sqx2  <= sqx1;
    sqy2  <= sqy1;
    ax2   <= ax1;
    ay2   <= ay1;
    gxa2  <= gxa1;
    gya2  <= gya1;
    tg2   <= tg1;
    neg2  <= gx1[GB-1] ^ gy1[GB-1];
    up1_2 <= up1_m;
    up2_2 <= up2_raw;

    ctrl3 <= ctrl2;
    c3    <= c2;
    mag3  <= mag2;
    up1_3 <= up1_2;
    up2_3 <= up2_2;
    dir3  <= dir2;
    neg3  <= neg2;

    ctrl4 <= ctrl3;
    c4    <= c3;

    if (rst) begin
      ctrl1.valid <= 1'b0;
      ctrl2.valid <= 1'b0;
      ctrl3.valid <= 1'b0;
      ctrl4.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl3.valid) begin
      cur_w[2]  <= mag3;
      row1_w[2] <= up1_3;
      row2_w[2] <= up2_3;
      dir_w[1]  <= dir3;
      neg_w[1]  <= neg3;
      dir_w[0]  <= dir_w[1];
      neg_w[0]  <= neg_w[1];
      if (c3 == '0) begin
        cur_w[1]  <= '0;
        cur_w[0]  <= '0;
        row1_w[1] <= '0;
        row1_w[0] <= '0;
        row2_w[1] <= '0;
        row2_w[0] <= '0;
      end else begin
        cur_w[1]  <= cur_w[2];
        cur_w[0]  <= cur_w[1];
        row1_w[1] <= row1_w[2];
        row1_w[0] <= row1_w[1];
        row2_w[1] <= row2_w[2];
        row2_w[0] <= row2_w[1];
      end
    end
  end

  cnms_classify #(.MAG_W(MW)) u_cls_prev (
    .low_thr  (low_thr),
    .high_thr (high_thr),
    .dir      (dir_w[0]),
    .neg      (neg_w[0]),
    .m        (row1_w[1]),
    .left     (row1_w[0]),
    .right    (row1_w[2]),
    .up_l     (row2_w[0]),
    .up_c     (row2_w[1]),
    .up_r     (row2_w[2]),
    .dn_l     (cur_w[0]),
    .dn_c     (cur_w[1]),
    .dn_r     (cur_w[2]),
    .cls      (cls_prev)
  );

  // right-hand neighbours of the last column lie outside the image
  cnms_classify #(.MAG_W(MW)) u_cls_last (
    .low_thr  (low_thr),
    .high_thr (high_thr),
    .dir      (dir_w[1]),
    .neg      (neg_w[1]),
    .m        (row1_w[2]),
    .left     (row1_w[1]),
    .right    ('0),
    .up_l     (row2_w[1]),
    .up_c     (row2_w[2]),
    .up_r     ('0),
    .dn_l     (cur_w[1]),
    .dn_c     (cur_w[2]),
    .dn_r     ('0),
    .cls      (cls_last)
  );

  always_comb begin
    prev_word.cls = cls_prev;
    prev_word.col = COL_W'(c4 - CW'(1));
    prev_word.eor = 1'b0;
    prev_word.eof = 1'b0;
    last_word.cls = cls_last;
    last_word.col = COL_W'(c4);
    last_word.eor = 1'b1;
    last_word.eof = ctrl4.eof;
    push0 = ctrl4.valid && (ctrl4.emit_prev || ctrl4.emit_last);
    push1 = ctrl4.valid && ctrl4.emit_prev && ctrl4.emit_last;
    word0 = ctrl4.emit_prev ? prev_word : last_word;
    word1 = last_word;
  end

endmodule

// ===== hw/rtl/cnms_outq.sv =====
module cnms_outq #(
  parameter int DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push0,
  input  logic              push1,
  input  cnms_pkg::result_t word0,
  input  cnms_pkg::result_t word1,
  input  logic              pop,
  output logic              empty,
  output logic              word_taken,
  output cnms_pkg::result_t head
);

  localparam int AW = $clog2(DEPTH);

  cnms_pkg::result_t mem [DEPTH];
  logic [AW:0]       wr_ptr;
  logic [AW:0]       rd_ptr;
  logic [AW-1:0]     wr_addr1;

  assign wr_addr1   = wr_ptr[AW-1:0] + 1'b1;
  assign empty      = wr_ptr == rd_ptr;
  assign word_taken = pop && !empty;
  assign head       = mem[rd_ptr[AW-1:0]];

  always_ff @(posedge clk) begin
    if (push0) begin
      mem[wr_ptr[AW-1:0]] <= word0;
    end
    if (push1) begin
      mem[wr_addr1] <= word1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      wr_ptr <= wr_ptr + {AW'(0), push0} + {AW'(0), push1};
      rd_ptr <= rd_ptr + {AW'(0), word_taken};
    end
  end

endmodule

// ===== hw/rtl/cnms_checker.sv =====
module cnms_checker (
  input logic        clk,
  input logic        rst,
  input logic        push,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic [1:0]  edge_class,
  input logic [10:0] pixel_column,
  input logic        end_of_row,
  input logic        end_of_frame
);

  // nothing waits and nothing is in flight right after reset
  a_reset_clear: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("queue not clear after reset");

  // a frame ends only on the last column of a row
  a_eof_on_eor: assert property (@(posedge clk) disable iff (rst)
    (!empty && end_of_frame) |-> end_of_row)
    else $error("end_of_frame without end_of_row");

  // class code three is never produced
  a_class_legal: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (edge_class == 2'd0 || edge_class == 2'd1 || edge_class == 2'd2))
    else $error("illegal edge_class");

  // a waiting word holds until it is taken
  a_head_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(edge_class) && $stable(pixel_column)
                          && $stable(end_of_row) && $stable(end_of_frame)))
    else $error("waiting word changed");

endmodule

bind canny_nonmax_suppression_core cnms_checker u_checker (.*);
